FILE: design/twbp_pkg.sv
// Shared types and constants for the 10-bit word / byte packer.
package twbp_pkg;

  localparam int WORD_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int PHASE_W = 3;
  localparam int QDEPTH  = 3;
  localparam int QCNT_W  = 2;

  // Last phase of a group in each mode.
  localparam logic [PHASE_W-1:0] UNPACK_LAST_PH = 3'd4;
  localparam logic [PHASE_W-1:0] PACK_LAST_PH   = 3'd3;

  typedef enum logic {
    DIR_UNPACK = 1'b0,
    DIR_PACK   = 1'b1
  } dir_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic              last_of_run;
  } res_t;

endpackage

FILE: design/twbp_ifs.sv
// Channel interfaces: input items, result items and the configuration write.
interface twbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [twbp_pkg::WORD_W-1:0]   data_in;
  logic                          restart;

  modport source (output valid, output data_in, output restart, input ready);
  modport sink   (input valid, input data_in, input restart, output ready);
endinterface

interface twbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [twbp_pkg::WORD_W-1:0]   data_out;
  logic                          last_of_run;

  modport source (output valid, output data_out, output last_of_run, input ready);
  modport sink   (input valid, input data_out, input last_of_run, output ready);
endinterface

interface twbp_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

FILE: design/ten_bit_word_byte_packer.sv
// Top level: streaming gearbox between 10-bit words and bytes (four words to five bytes).
// A result is registered into the result queue and is valid on out_ch once those before it are taken.
// Throughput: one input transaction per cycle while at most one result is queued; a pack
//   group's fourth word puts two bytes in the three-entry queue and stalls the input.
// Reset (rst_n low, synchronous): direction = unpack, phase and residual cleared,
//   result queue emptied; in_ch and cfg_ch are not ready while reset is held.
module ten_bit_word_byte_packer (
  input  logic        clk,
  input  logic        rst_n,
  twbp_in_if.sink     in_ch,
  twbp_out_if.source  out_ch,
  twbp_cfg_if.sink    cfg_ch
);

  // Mode register and group state.
  twbp_pkg::dir_t                        dir_r;
  logic [twbp_pkg::PHASE_W-1:0]          phase_r, phase_nxt;
  logic [twbp_pkg::BYTE_W-1:0]           resid_r, resid_nxt;

  // Result queue: entry 0 is the head shown on out_ch.
  twbp_pkg::res_t                        q_r   [twbp_pkg::QDEPTH];
  twbp_pkg::res_t                        q_nxt [twbp_pkg::QDEPTH];
  logic [twbp_pkg::QCNT_W-1:0]           cnt_r, cnt_nxt, cnt_pop;

  logic                                  in_acc, out_pop;
  logic [1:0]                            n_res;
  twbp_pkg::res_t                        res0, res1;
  logic [twbp_pkg::PHASE_W-1:0]          ph;
  logic [twbp_pkg::BYTE_W-1:0]           b;
  logic [twbp_pkg::WORD_W-1:0]           d;
  logic [twbp_pkg::WORD_W-1:0]           resid_w;

  // Accept input only with room for two results, so a result waiting on
  // out_ch never blocks the next item.
  assign in_ch.ready  = rst_n && (cnt_r <= 2'd1);
  assign cfg_ch.ready = rst_n;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_pop      = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.data_out    = q_r[0].data_out;
  assign out_ch.last_of_run = q_r[0].last_of_run;

  assign d       = in_ch.data_in;
  assign b       = in_ch.data_in[twbp_pkg::BYTE_W-1:0];
  assign resid_w = {2'b00, resid_r};

  // Gearbox: one pass per item, picking the bit slices for the current phase.
  always_comb begin
    ph        = in_ch.restart ? '0 : phase_r;
    n_res     = 2'd1;
    res0      = '{data_out: '0, last_of_run: 1'b1};
    res1      = '{data_out: '0, last_of_run: 1'b1};
    resid_nxt = '0;
    phase_nxt = '0;
    if (dir_r == twbp_pkg::DIR_UNPACK) begin
      // An out-of-range phase restarts the group.
      if (ph > twbp_pkg::UNPACK_LAST_PH) begin
        ph = '0;
      end
      case (ph)
        3'd0: begin
          // First byte of a group only fills the residual.
          n_res     = 2'd0;
          resid_nxt = b;
        end
        3'd1: begin
          res0.data_out = {b[1:0], 8'h00} | resid_w;
          resid_nxt     = {2'b00, b[7:2]};
        end
        3'd2: begin
          res0.data_out = {b[3:0], 6'h00} | resid_w;
          resid_nxt     = {4'h0, b[7:4]};
        end
        3'd3: begin
          res0.data_out = {b[5:0], 4'h0} | resid_w;
          resid_nxt     = {6'h00, b[7:6]};
        end
        default: begin
          res0.data_out = {b, 2'b00} | resid_w;
          resid_nxt     = '0;
        end
      endcase
      phase_nxt = (ph >= twbp_pkg::UNPACK_LAST_PH) ? '0 : ph + 3'd1;
    end else begin
      if (ph > twbp_pkg::PACK_LAST_PH) begin
        ph = '0;
      end
      case (ph)
        3'd0: begin
          res0.data_out = {2'b00, d[7:0]};
          resid_nxt     = {6'h00, d[9:8]};
        end
        3'd1: begin
          res0.data_out = {2'b00, {d[5:0], 2'b00} | resid_r};
          resid_nxt     = {4'h0, d[9:6]};
        end
        3'd2: begin
          res0.data_out = {2'b00, {d[3:0], 4'h0} | resid_r};
          resid_nxt     = {2'b00, d[9:4]};
        end
        default: begin
          // Fourth word closes the group with two bytes.
          n_res            = 2'd2;
          res0.data_out    = {2'b00, {d[1:0], 6'h00} | resid_r};
          res0.last_of_run = 1'b0;
          res1.data_out    = {2'b00, d[9:2]};
          resid_nxt        = '0;
        end
      endcase
      phase_nxt = (ph >= twbp_pkg::PACK_LAST_PH) ? '0 : ph + 3'd1;
    end
  end

  // Queue update: drop the head on a pop, then append new results behind.
  always_comb begin
    cnt_pop = cnt_r - {1'b0, out_pop};
    for (int i = 0; i < twbp_pkg::QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (out_pop) begin
      for (int i = 0; i < twbp_pkg::QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    cnt_nxt = cnt_pop;
    if (in_acc) begin
      for (int i = 0; i < twbp_pkg::QDEPTH; i++) begin
        if ((n_res != 2'd0) && (twbp_pkg::QCNT_W'(i) == cnt_pop)) begin
          q_nxt[i] = res0;
        end
        if ((n_res == 2'd2) && (3'(i) == {1'b0, cnt_pop} + 3'd1)) begin
          q_nxt[i] = res1;
        end
      end
      cnt_nxt = cnt_pop + n_res;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= twbp_pkg::DIR_UNPACK;
      phase_r <= '0;
      resid_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        dir_r <= twbp_pkg::dir_t'(cfg_ch.direction);
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        resid_r <= resid_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    for (int i = 0; i < twbp_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

FILE: design/twbp_checker.sv
// Port-level assertions for the packer and the bind that attaches them.
module twbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_data,
  input logic       out_last
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("result changed while stalled");

  // Results appear only after an input transaction.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transaction");

  // Input backpressure only follows an input transaction.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without a transaction");

  // Input is blocked only while results wait.
  a_block_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no pending result");

endmodule

bind ten_bit_word_byte_packer twbp_checker u_twbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_out),
  .out_last  (out_ch.last_of_run)
);
